>>> rtl/core/modbus_encoder_rope_length_tracker_unit_assert.svh
// assertion macros used by the tracker rtl
`ifndef MODBUS_ENCODER_ROPE_LENGTH_TRACKER_UNIT_ASSERT_SVH
`define MODBUS_ENCODER_ROPE_LENGTH_TRACKER_UNIT_ASSERT_SVH

// same-cycle implication
`define MRLT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mrlt assertion failed");

// next-cycle implication
`define MRLT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mrlt assertion failed");

`endif

>>> rtl/core/mrlt_pkg.sv
`timescale 1ns / 1ps
package mrlt_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 16;
    localparam int KEPT_BYTES          = 7;

    // request codes
    localparam logic [1:0] FUNC_MEASURE = 2'd0;
    localparam logic [1:0] FUNC_ZERO    = 2'd1;
    localparam logic [1:0] FUNC_REBASE  = 2'd2;
    localparam logic [1:0] FUNC_RESTORE = 2'd3;

    // result status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_SHORT      = 3'd1;
    localparam logic [2:0] ST_BAD_ADDR   = 3'd2;
    localparam logic [2:0] ST_BAD_FUNC   = 3'd3;
    localparam logic [2:0] ST_BAD_COUNT  = 3'd4;

    // frame constants
    localparam logic [7:0] FC_READ_HOLD  = 8'h03;
    localparam logic [7:0] BC_TWO        = 8'h02;
    localparam logic [7:0] BC_FOUR       = 8'h04;

    // configuration register indexes
    localparam int         CFG_IDX_W       = 3;
    localparam int         CFG_DATA_W      = 48;
    localparam logic [2:0] CFG_SLAVE_ADDR  = 3'd0;
    localparam logic [2:0] CFG_COUNTS      = 3'd1;
    localparam logic [2:0] CFG_LEN_PER     = 3'd2;
    localparam logic [2:0] CFG_BASE_SET    = 3'd3;
    localparam logic [2:0] CFG_ZERO_SET    = 3'd4;

    localparam logic [7:0]  RST_SLAVE_ADDR = 8'd1;
    localparam logic [24:0] RST_COUNTS     = 25'd4096;
    localparam logic [31:0] RST_LEN_PER    = 32'd20588940;

    // shared divider
    localparam int DIV_W     = 64;
    localparam int DIV_REM_W = 25;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    localparam int ANGLE_W = 57;
    localparam int LEN_W   = 48;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] value;
    } t_frame_chk;

endpackage

>>> rtl/core/mrlt_div.sv
`timescale 1ns / 1ps
module mrlt_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [mrlt_pkg::DIV_W-1:0]         i_dividend,
    input  logic [mrlt_pkg::DIV_REM_W-1:0]     i_divisor,
    output logic                               o_busy,
    output logic                               o_done,
    output logic [mrlt_pkg::DIV_W-1:0]         o_quotient
);

    logic [mrlt_pkg::DIV_W-1:0]     r_q;
    logic [mrlt_pkg::DIV_REM_W-1:0] r_rem;
    logic [mrlt_pkg::DIV_REM_W-1:0] r_div;
    logic [mrlt_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                           r_busy;
    logic                           r_done;

    logic [mrlt_pkg::DIV_REM_W:0]   rem_sh;
    logic [mrlt_pkg::DIV_REM_W+1:0] diff;
    logic                           ge;

    // one restoring step: bring down the next dividend bit
    assign rem_sh = {r_rem, r_q[mrlt_pkg::DIV_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, r_div};
    assign ge     = !diff[mrlt_pkg::DIV_REM_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= mrlt_pkg::DIV_CNT_W'(mrlt_pkg::DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == mrlt_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[mrlt_pkg::DIV_W-2:0], ge};
            r_rem <= ge ? diff[mrlt_pkg::DIV_REM_W-1:0] : rem_sh[mrlt_pkg::DIV_REM_W-1:0];
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

>>> rtl/core/mrlt_frame.sv
`timescale 1ns / 1ps
module mrlt_frame #(
    parameter int MAX_FRAME_BYTES = mrlt_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr,
    input  logic [7:0]           i_byte,
    input  logic                 i_last,
    input  logic [7:0]           i_slave_addr,
    output mrlt_pkg::t_frame_chk o_chk
);

    localparam int PW = $clog2(MAX_FRAME_BYTES + 1);

    logic [PW-1:0] r_pos;
    logic [PW-1:0] n_pos;
    logic          r_short;
    logic [7:0]    r_bytes [0:mrlt_pkg::KEPT_BYTES-1];

    // count saturates at the frame limit, later bytes are dropped
    assign n_pos = (r_pos < PW'(MAX_FRAME_BYTES)) ? r_pos + 1'b1 : r_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_short <= 1'b0;
        end else if (i_wr) begin
            if (i_last) begin
                r_pos   <= '0;
                r_short <= n_pos < PW'(mrlt_pkg::KEPT_BYTES);
            end else begin
                r_pos <= n_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < mrlt_pkg::KEPT_BYTES; k++) begin
            if (i_wr && r_pos == PW'(k)) begin
                r_bytes[k] <= i_byte;
            end
        end
    end

    always_comb begin
        o_chk.status = mrlt_pkg::ST_OK;
        if (r_short) begin
            o_chk.status = mrlt_pkg::ST_SHORT;
        end else if (r_bytes[0] != i_slave_addr) begin
            o_chk.status = mrlt_pkg::ST_BAD_ADDR;
        end else if (r_bytes[1] != mrlt_pkg::FC_READ_HOLD) begin
            o_chk.status = mrlt_pkg::ST_BAD_FUNC;
        end else if (r_bytes[2] != mrlt_pkg::BC_FOUR && r_bytes[2] != mrlt_pkg::BC_TWO) begin
            o_chk.status = mrlt_pkg::ST_BAD_COUNT;
        end
        // big-endian register payload
        if (r_bytes[2] == mrlt_pkg::BC_FOUR) begin
            o_chk.value = {r_bytes[3], r_bytes[4], r_bytes[5], r_bytes[6]};
        end else begin
            o_chk.value = {16'h0000, r_bytes[3], r_bytes[4]};
        end
    end

endmodule

>>> rtl/core/modbus_encoder_rope_length_tracker_unit.sv
`timescale 1ns / 1ps
// channel | direction | handshake                  | payload
// in      | in        | i_in_valid / o_in_ready    | i_func, i_rx_byte, i_frame_end
// out     | out       | o_out_valid / i_out_ready  | o_status, o_turn_value, o_angle,
//         |           |                            | o_rope_length
// cfg     | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// a byte that does not end a frame, and a restore request, leave the sequencer idle
// a frame end runs through check, 64-step angle division, multiply,
// 64-step length division, write-back; a zero calibration skips the second division
// all of it goes through one shared bit-serial divider
// synchronous active-low reset; no clearing pass, captured bytes need no reset
// a finished result waits in the output register; non-final bytes are still taken,
// a further frame end holds at write-back until the result is taken
module modbus_encoder_rope_length_tracker_unit #(
    parameter int MAX_FRAME_BYTES = mrlt_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [1:0]                          i_func,
    input  logic [7:0]                          i_rx_byte,
    input  logic                                i_frame_end,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [2:0]                          o_status,
    output logic [31:0]                         o_turn_value,
    output logic [mrlt_pkg::ANGLE_W-1:0]        o_angle,
    output logic signed [mrlt_pkg::LEN_W-1:0]   o_rope_length,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mrlt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mrlt_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    `include "modbus_encoder_rope_length_tracker_unit_assert.svh"

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_ANG   = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_LEN   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    localparam int SUM_W = mrlt_pkg::LEN_W + 2;

    // configuration
    logic [7:0]                      r_slave_addr;
    logic [24:0]                     r_counts;
    logic [31:0]                     r_len_per;
    logic [mrlt_pkg::LEN_W-1:0]      r_base_set;
    logic [31:0]                     r_zero_set;

    // tracking state
    logic [31:0]                     r_zero;
    logic [mrlt_pkg::LEN_W-1:0]      r_base;

    // sequencer
    logic [2:0]                      r_state;
    logic [1:0]                      r_func;
    logic [2:0]                      r_st;
    logic [31:0]                     r_val;
    logic [mrlt_pkg::ANGLE_W-1:0]    r_ang;
    logic [mrlt_pkg::LEN_W-1:0]      r_len;
    logic [31:0]                     r_mag;
    logic                            r_neg;

    // output register
    logic                            r_out_valid;
    logic [2:0]                      r_out_st;
    logic [31:0]                     r_out_val;
    logic [mrlt_pkg::ANGLE_W-1:0]    r_out_ang;
    logic [mrlt_pkg::LEN_W-1:0]      r_out_len;

    logic                            in_acc;
    logic                            frame_wr;
    mrlt_pkg::t_frame_chk            chk;

    logic                            div_start;
    logic [mrlt_pkg::DIV_W-1:0]      div_dividend;
    logic [mrlt_pkg::DIV_REM_W-1:0]  divisor;
    logic                            div_busy;
    logic                            div_done;
    logic [mrlt_pkg::DIV_W-1:0]      div_q;

    logic [40:0]                     val_x360;
    logic [48:0]                     q_clamp;
    logic signed [SUM_W-1:0]         delta;
    logic signed [SUM_W-1:0]         sum;
    logic [mrlt_pkg::LEN_W-1:0]      sum_sat;
    logic                            out_free;

    assign in_acc      = i_in_valid && o_in_ready;
    assign frame_wr    = in_acc && i_func != mrlt_pkg::FUNC_RESTORE;
    assign o_in_ready  = r_state == S_IDLE;
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || i_out_ready;

    mrlt_frame #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (frame_wr),
        .i_byte      (i_rx_byte),
        .i_last      (i_frame_end),
        .i_slave_addr(r_slave_addr),
        .o_chk       (chk)
    );

    // zero counts per turn behaves as one
    assign divisor  = (r_counts == '0) ? mrlt_pkg::DIV_REM_W'(1) : r_counts;
    assign val_x360 = {9'd0, chk.value} * 41'd360;

    always_comb begin
        div_start    = 1'b0;
        div_dividend = {7'd0, val_x360, 16'd0};
        if (r_state == S_CHECK && chk.status == mrlt_pkg::ST_OK) begin
            div_start = 1'b1;
        end else if (r_state == S_MUL) begin
            div_start    = 1'b1;
            div_dividend = {32'd0, r_mag} * {32'd0, r_len_per};
        end
    end

    mrlt_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dividend(div_dividend),
        .i_divisor (divisor),
        .o_busy    (div_busy),
        .o_done    (div_done),
        .o_quotient(div_q)
    );

    // quotient clamped to 2^48, signed add with base, saturate to 48 bits
    always_comb begin
        q_clamp = (|div_q[63:48]) ? {1'b1, 48'd0} : {1'b0, div_q[47:0]};
        delta   = r_neg ? -$signed({1'b0, q_clamp}) : $signed({1'b0, q_clamp});
        sum     = $signed({{2{r_base[mrlt_pkg::LEN_W-1]}}, r_base}) + delta;
        if (sum[SUM_W-1:mrlt_pkg::LEN_W-1] == '0 || sum[SUM_W-1:mrlt_pkg::LEN_W-1] == '1) begin
            sum_sat = sum[mrlt_pkg::LEN_W-1:0];
        end else if (sum[SUM_W-1]) begin
            sum_sat = {1'b1, {(mrlt_pkg::LEN_W-1){1'b0}}};
        end else begin
            sum_sat = {1'b0, {(mrlt_pkg::LEN_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_addr <= mrlt_pkg::RST_SLAVE_ADDR;
            r_counts     <= mrlt_pkg::RST_COUNTS;
            r_len_per    <= mrlt_pkg::RST_LEN_PER;
            r_base_set   <= '0;
            r_zero_set   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mrlt_pkg::CFG_SLAVE_ADDR: r_slave_addr <= i_cfg_data[7:0];
                mrlt_pkg::CFG_COUNTS:     r_counts     <= i_cfg_data[24:0];
                mrlt_pkg::CFG_LEN_PER:    r_len_per    <= i_cfg_data[31:0];
                mrlt_pkg::CFG_BASE_SET:   r_base_set   <= i_cfg_data[mrlt_pkg::LEN_W-1:0];
                mrlt_pkg::CFG_ZERO_SET:   r_zero_set   <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_zero      <= '0;
            r_base      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_func == mrlt_pkg::FUNC_RESTORE) begin
                            r_zero <= r_zero_set;
                            r_base <= r_base_set;
                        end else if (i_frame_end) begin
                            r_state <= S_CHECK;
                        end
                    end
                end
                S_CHECK: begin
                    if (chk.status == mrlt_pkg::ST_OK) begin
                        r_state <= S_ANG;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_ANG: begin
                    if (div_done) begin
                        if (r_func == mrlt_pkg::FUNC_ZERO) begin
                            r_zero  <= r_val;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_state <= S_LEN;
                end
                S_LEN: begin
                    if (div_done) begin
                        if (r_func == mrlt_pkg::FUNC_REBASE) begin
                            r_base <= sum_sat;
                            r_zero <= r_val;
                        end
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && in_acc) begin
            r_func <= i_func;
        end
        if (r_state == S_CHECK) begin
            r_st  <= chk.status;
            r_val <= (chk.status == mrlt_pkg::ST_OK) ? chk.value : 32'd0;
            r_ang <= '0;
            r_len <= '0;
        end
        if (r_state == S_ANG && div_done) begin
            r_ang <= div_q[mrlt_pkg::ANGLE_W-1:0];
            r_neg <= r_val < r_zero;
            r_mag <= (r_val < r_zero) ? r_zero - r_val : r_val - r_zero;
            if (r_func == mrlt_pkg::FUNC_ZERO) begin
                r_len <= r_base;
            end
        end
        if (r_state == S_LEN && div_done) begin
            r_len <= sum_sat;
        end
        if (r_state == S_OUT && out_free) begin
            r_out_st  <= r_st;
            r_out_val <= r_val;
            r_out_ang <= r_ang;
            r_out_len <= r_len;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_st;
    assign o_turn_value  = r_out_val;
    assign o_angle       = r_out_ang;
    assign o_rope_length = $signed(r_out_len);

    `MRLT_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, o_out_valid && o_status != mrlt_pkg::ST_OK, o_turn_value == '0 && o_angle == '0 && o_rope_length == '0)
    `MRLT_ASSERT_IMP(a_div_idle_start, i_clk, i_rst_n, div_start, !div_busy)
    `MRLT_ASSERT_NXT(a_end_to_check, i_clk, i_rst_n, frame_wr && i_frame_end, r_state == S_CHECK)

endmodule
